// ----- rtl/core/vertex_rotate_scale_translate_defines.svh -----
// Assertion macros for the vertex transform checker.
// Depends on nothing; included by files that hold assertions.
`ifndef VERTEX_ROTATE_SCALE_TRANSLATE_DEFINES_SVH
`define VERTEX_ROTATE_SCALE_TRANSLATE_DEFINES_SVH

// Assert that a condition implies a consequent, clocked on clk, off in reset.
`define VRST_ASSERT_IMPL(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Assert that a condition is followed by a consequent, delayed by the given n.
`define VRST_ASSERT_DELAY(label, cond, n, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##n (conseq)) \
        else $error(msg);

`endif

// ----- rtl/core/vrst_pkg.sv -----
// Package for the vertex transform: widths, pipeline layout, register indexes, stage type and helpers.
// Depends on nothing; used by the top level and its checker.
package vrst_pkg;

    localparam int COORD_BITS = 16;
    localparam int GUARD_BITS = 8;
    localparam int INT_W      = COORD_BITS + GUARD_BITS + 4;
    localparam int ANG_W      = 16;
    localparam int CFG_W      = 16;
    localparam int ITERS      = 16;
    localparam int NROT       = 3;
    // One quarter-turn stage, the iterations and one gain stage per rotation.
    localparam int RSTG       = ITERS + 2;
    localparam int NSTG       = NROT * RSTG;
    // Accept edge to the sampled strobe: input stage, rotations, two finish stages.
    localparam int LATENCY    = NSTG + 3;
    localparam int GAIN_W     = 18;
    localparam int GPROD_W    = INT_W + GAIN_W;
    localparam int SPROD_W    = INT_W + CFG_W;
    localparam int SUM_W      = INT_W - 3;

    localparam logic signed [GAIN_W-1:0] INV_GAIN = 18'sd39797;

    // Register indexes.
    localparam logic [2:0] REG_ANGLE_X = 3'd0;
    localparam logic [2:0] REG_ANGLE_Y = 3'd1;
    localparam logic [2:0] REG_ANGLE_Z = 3'd2;
    localparam logic [2:0] REG_SCALE_X = 3'd3;
    localparam logic [2:0] REG_SCALE_Y = 3'd4;
    localparam logic [2:0] REG_SCALE_Z = 3'd5;
    localparam logic [2:0] REG_SHIFT_X = 3'd6;
    localparam logic [2:0] REG_SHIFT_Y = 3'd7;

    // Payload carried by each pipeline stage.
    typedef struct packed {
        logic signed [INT_W-1:0] x;
        logic signed [INT_W-1:0] y;
        logic signed [INT_W-1:0] z;
        logic signed [ANG_W-1:0] r;
        logic                    last;
    } stg_t;

    // Arctangent of 2^-i in units of a full turn times 65536.
    function automatic logic signed [ANG_W-1:0] atan_of(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 16'sd8192;
            1:       v = 16'sd4836;
            2:       v = 16'sd2555;
            3:       v = 16'sd1297;
            4:       v = 16'sd651;
            5:       v = 16'sd326;
            6:       v = 16'sd163;
            7:       v = 16'sd81;
            8:       v = 16'sd41;
            9:       v = 16'sd20;
            10:      v = 16'sd10;
            11:      v = 16'sd5;
            12:      v = 16'sd3;
            13:      v = 16'sd1;
            14:      v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // Clamp a rounded sum to the signed coordinate range.
    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [COORD_BITS-1:0] res;
        hi = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
        lo = SUM_W'(-(64'sd1 <<< (COORD_BITS - 1)));
        if (v > hi)
            res = hi[COORD_BITS-1:0];
        else if (v < lo)
            res = lo[COORD_BITS-1:0];
        else
            res = v[COORD_BITS-1:0];
        return res;
    endfunction

endpackage

// ----- rtl/core/vertex_rotate_scale_translate.sv -----
// Top level of the vertex transform: rotate about X, Y, Z, scale, shift X and Y, saturate.
// Depends on vrst_pkg.
//
// One vertex is taken at every clock edge with start high; busy is always low, so a
// vertex may follow in the very next cycle. Each vertex leaves with done high for one
// cycle, vrst_pkg::LATENCY after its accept edge (LATENCY counts to the edge that
// samples done). Between the two lie the input stage and three rotations, each of one
// quarter-turn stage, sixteen CORDIC stages and one gain multiply stage, followed by
// a scale multiply stage and a round-and-saturate output stage.
// The receiver cannot stall; results are shown once and must be taken.
module vertex_rotate_scale_translate
    import vrst_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_z,
    input  logic                         in_last,
    output logic                         done,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic                         out_last,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_addr,
    input  logic [CFG_W-1:0]             cfg_wdata
);

    logic [ANG_W-1:0]        angle_x_reg, angle_y_reg, angle_z_reg;
    logic signed [CFG_W-1:0] scale_x_reg, scale_y_reg, scale_z_reg;
    logic signed [CFG_W-1:0] shift_x_reg, shift_y_reg;

    stg_t stg_reg [0:NSTG];
    logic vld_reg [0:NSTG];

    logic signed [SPROD_W-1:0] px_reg, py_reg, pz_reg;
    logic                      plast_reg;
    logic                      pvld_reg;

    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                         out_last_reg;
    logic                         done_reg;

    // The pipeline never holds off a beat.
    assign busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            scale_x_reg <= 16'sd4096;
            scale_y_reg <= 16'sd4096;
            scale_z_reg <= 16'sd4096;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ANGLE_X: angle_x_reg <= cfg_wdata;
                REG_ANGLE_Y: angle_y_reg <= cfg_wdata;
                REG_ANGLE_Z: angle_z_reg <= cfg_wdata;
                REG_SCALE_X: scale_x_reg <= cfg_wdata;
                REG_SCALE_Y: scale_y_reg <= cfg_wdata;
                REG_SCALE_Z: scale_z_reg <= cfg_wdata;
                REG_SHIFT_X: shift_x_reg <= cfg_wdata;
                REG_SHIFT_Y: shift_y_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Input stage: widen and add guard bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= start;
    end

    always_ff @(posedge clk)
    begin
        stg_reg[0].x    <= INT_W'(in_x) <<< GUARD_BITS;
        stg_reg[0].y    <= INT_W'(in_y) <<< GUARD_BITS;
        stg_reg[0].z    <= INT_W'(in_z) <<< GUARD_BITS;
        stg_reg[0].r    <= '0;
        stg_reg[0].last <= in_last;
    end

    // Rotation pipeline: each stage does one quarter turn, one CORDIC step or one gain.
    for (genvar s = 0; s < NSTG; s++)
    begin : g_stg
        localparam int R = s / RSTG;
        localparam int K = s % RSTG;

        stg_t                     cur;
        stg_t                     stg_next;
        logic [ANG_W-1:0]         ang;
        logic [ANG_W-1:0]         ang_sum;
        logic signed [INT_W-1:0]  a, b, an, bn;
        logic signed [ANG_W-1:0]  rn;
        logic signed [GPROD_W-1:0] pa, pb;

        always_comb
        begin
            cur = stg_reg[s];
            if (R == 0)
            begin
                a   = cur.y;
                b   = cur.z;
                ang = angle_x_reg;
            end
            else if (R == 1)
            begin
                a   = cur.x;
                b   = cur.z;
                ang = angle_y_reg;
            end
            else
            begin
                a   = cur.x;
                b   = cur.y;
                ang = angle_z_reg;
            end
            ang_sum = ang + 16'd8192;
            pa = GPROD_W'(a) * GPROD_W'(INV_GAIN);
            pb = GPROD_W'(b) * GPROD_W'(INV_GAIN);
            an = a;
            bn = b;
            rn = cur.r;
            if (K == 0)
            begin
                // Exact quarter turns, then the residual angle.
                rn = $signed({2'b00, ang_sum[13:0]}) - 16'sd8192;
                case (ang_sum[15:14])
                    2'd1:
                    begin
                        an = -b;
                        bn = a;
                    end
                    2'd2:
                    begin
                        an = -a;
                        bn = -b;
                    end
                    2'd3:
                    begin
                        an = b;
                        bn = -a;
                    end
                    default:
                    begin
                        an = a;
                        bn = b;
                    end
                endcase
            end
            else if (K <= ITERS)
            begin
                // One CORDIC micro-rotation toward zero residual.
                if (!cur.r[ANG_W-1])
                begin
                    an = a - (b >>> (K - 1));
                    bn = b + (a >>> (K - 1));
                    rn = cur.r - atan_of(K - 1);
                end
                else
                begin
                    an = a + (b >>> (K - 1));
                    bn = b - (a >>> (K - 1));
                    rn = cur.r + atan_of(K - 1);
                end
            end
            else
            begin
                // Remove the CORDIC gain.
                an = INT_W'(pa >>> 16);
                bn = INT_W'(pb >>> 16);
            end
            stg_next   = cur;
            stg_next.r = rn;
            if (R == 0)
            begin
                stg_next.y = an;
                stg_next.z = bn;
            end
            else if (R == 1)
            begin
                stg_next.x = an;
                stg_next.z = bn;
            end
            else
            begin
                stg_next.x = an;
                stg_next.y = bn;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            stg_reg[s+1] <= stg_next;
        end
    end

    // Scale multiply stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pvld_reg <= 1'b0;
        else
            pvld_reg <= vld_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= SPROD_W'(stg_reg[NSTG].x) * SPROD_W'(scale_x_reg);
        py_reg    <= SPROD_W'(stg_reg[NSTG].y) * SPROD_W'(scale_y_reg);
        pz_reg    <= SPROD_W'(stg_reg[NSTG].z) * SPROD_W'(scale_z_reg);
        plast_reg <= stg_reg[NSTG].last;
    end

    // Round half up, add the X and Y shifts and saturate.
    logic signed [SPROD_W-1:0] rx, ry, rz;
    logic signed [SUM_W-1:0]   sx_next, sy_next, sz_next;

    always_comb
    begin
        rx = (px_reg + (SPROD_W'(1) <<< (11 + GUARD_BITS))) >>> (12 + GUARD_BITS);
        ry = (py_reg + (SPROD_W'(1) <<< (11 + GUARD_BITS))) >>> (12 + GUARD_BITS);
        rz = (pz_reg + (SPROD_W'(1) <<< (11 + GUARD_BITS))) >>> (12 + GUARD_BITS);
        sx_next = SUM_W'(rx) + SUM_W'(shift_x_reg);
        sy_next = SUM_W'(ry) + SUM_W'(shift_y_reg);
        sz_next = SUM_W'(rz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= pvld_reg;
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= sat(sx_next);
        out_y_reg    <= sat(sy_next);
        out_z_reg    <= sat(sz_next);
        out_last_reg <= plast_reg;
    end

    assign done     = done_reg;
    assign out_x    = out_x_reg;
    assign out_y    = out_y_reg;
    assign out_z    = out_z_reg;
    assign out_last = out_last_reg;

endmodule

// ----- rtl/core/vrst_checker.sv -----
// Port-level checker for the vertex transform, bound to the top level.
// Depends on vrst_pkg and vertex_rotate_scale_translate_defines.svh.
`include "vertex_rotate_scale_translate_defines.svh"

module vrst_checker
    import vrst_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic in_last,
    input logic done,
    input logic out_last
);

    // Every accepted beat comes out after the fixed latency.
    `VRST_ASSERT_DELAY(a_beat_out, start && !busy, LATENCY, done, "accepted beat did not emerge")

    // No result appears without a beat accepted at the matching edge.
    `VRST_ASSERT_IMPL(a_no_phantom, done, $past(start && !busy, LATENCY), "result with no source beat")

    // The last-vertex mark travels with its vertex.
    `VRST_ASSERT_IMPL(a_last_kept, done, out_last == $past(in_last, LATENCY), "last mark mismatch")

endmodule

bind vertex_rotate_scale_translate vrst_checker u_vrst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_last  (in_last),
    .done     (done),
    .out_last (out_last)
);
